// File: rtl/tca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_pkg: shared types and constants for threshold cluster assignment
// Holds the item structs, table sizes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package tca_pkg;

	localparam int MAX_CLUSTERS = 256;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int SQ_W         = 2 * COORD_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int THR_W        = 34;
	localparam int ENTRY_W      = 3 * COORD_W;
	localparam int OUT_IDX_W    = 8;

	localparam logic KIND_CLASSIFY = 1'b0;
	localparam logic KIND_CLEAR    = 1'b1;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] coord_0;
		logic signed [COORD_W-1:0] coord_1;
		logic signed [COORD_W-1:0] coord_2;
	} tca_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mode_0;
		logic signed [COORD_W-1:0] mode_1;
		logic signed [COORD_W-1:0] mode_2;
		logic [OUT_IDX_W-1:0]      cluster_index;
		logic                      new_cluster;
		logic                      table_full;
	} tca_out_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic issue;
		logic take_hit;
		logic append;
		logic flush;
	} tca_cmd_t;

	typedef struct packed {
		logic more;
		logic pipe_busy;
		logic hit;
	} tca_status_t;

endpackage

// File: rtl/tca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_ctrl: scan controller
// Sequences acceptance, the mode table walk and the final append or report.
// ----------------------------------------------------------------------------
module tca_ctrl
	import tca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        kind,
	input  tca_status_t status,
	output tca_cmd_t    cmd,
	output logic        busy
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_SCAN = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind == KIND_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.take_hit = 1'b1;
					cmd.flush    = 1'b1;
					state_d      = ST_IDLE;
				end else if (status.more) begin
					cmd.issue = 1'b1;
				end else if (!status.pipe_busy) begin
					cmd.append = 1'b1;
					cmd.flush  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_SCAN);

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take_hit && cmd.append))
		else $error("Hit and append issued together.");

	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || cmd.append || cmd.take_hit) |-> busy)
		else $error("Scan command outside of a scan.");

endmodule

// File: rtl/tca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_dp: mode table and distance pipeline
// Reads one stored mode per cycle, squares and sums the axis differences,
// compares against the threshold, and builds the result item.
// ----------------------------------------------------------------------------
module tca_dp
	import tca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tca_cmd_t          cmd,
	input  tca_in_t           point,
	input  logic [THR_W-1:0]  threshold,
	output tca_status_t       status,
	output tca_out_t          result,
	output logic              done
);

	logic [ENTRY_W-1:0] mode_mem [MAX_CLUSTERS];

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_addr_q;
	logic [ENTRY_W-1:0] pt_q;

	logic               valid_s1;
	logic [ENTRY_W-1:0] mode_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               valid_s2;
	logic [ENTRY_W-1:0] mode_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [SQ_W-1:0]    sq_s2 [3];

	logic               hit_s3;
	logic [ENTRY_W-1:0] mode_s3;
	logic [IDX_W-1:0]   idx_s3;

	tca_out_t           res_q;
	logic               done_q;

	logic               full;
	logic [SQ_W-1:0]    sq [3];
	logic [SUM_W-1:0]   dist_sum;

	assign full = (count_q == CNT_W'(MAX_CLUSTERS));

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			logic signed [DIFF_W-1:0]   pc;
			logic signed [DIFF_W-1:0]   mc;
			logic signed [DIFF_W-1:0]   diff;
			logic signed [2*DIFF_W-1:0] prod;
			pc    = DIFF_W'($signed(pt_q[d*COORD_W +: COORD_W]));
			mc    = DIFF_W'($signed(mode_s1[d*COORD_W +: COORD_W]));
			diff  = pc - mc;
			prod  = diff * diff;
			sq[d] = prod[SQ_W-1:0];
		end
	end

	assign dist_sum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mode_mem[count_q[IDX_W-1:0]] <= pt_q;
		end
		if (cmd.issue) begin
			mode_s1 <= mode_mem[scan_addr_q[IDX_W-1:0]];
			idx_s1  <= scan_addr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_q <= {point.coord_2, point.coord_1, point.coord_0};
		end
		mode_s2 <= mode_s1;
		idx_s2  <= idx_s1;
		for (int d = 0; d < 3; d++) begin
			sq_s2[d] <= sq[d];
		end
		mode_s3 <= mode_s2;
		idx_s3  <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_addr_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			hit_s3      <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue && !cmd.flush;
			valid_s2 <= valid_s1 && !cmd.flush;
			hit_s3   <= valid_s2 && !cmd.flush && (dist_sum <= SUM_W'(threshold));
			if (cmd.load) begin
				scan_addr_q <= '0;
			end else if (cmd.issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			res_q <= '0;
		end else if (cmd.take_hit) begin
			res_q.mode_0        <= mode_s3[0*COORD_W +: COORD_W];
			res_q.mode_1        <= mode_s3[1*COORD_W +: COORD_W];
			res_q.mode_2        <= mode_s3[2*COORD_W +: COORD_W];
			res_q.cluster_index <= OUT_IDX_W'(idx_s3);
			res_q.new_cluster   <= 1'b0;
			res_q.table_full    <= 1'b0;
		end else if (cmd.append) begin
			res_q.mode_0        <= pt_q[0*COORD_W +: COORD_W];
			res_q.mode_1        <= pt_q[1*COORD_W +: COORD_W];
			res_q.mode_2        <= pt_q[2*COORD_W +: COORD_W];
			res_q.cluster_index <= full ? '0 : OUT_IDX_W'(count_q[IDX_W-1:0]);
			res_q.new_cluster   <= !full;
			res_q.table_full    <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.clear || cmd.take_hit || cmd.append;
		end
	end

	assign status.more      = (scan_addr_q < count_q);
	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.hit       = hit_s3;
	assign result           = res_q;
	assign done             = done_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CLUSTERS))
		else $error("Mode count exceeds the table size.");

	a_hit_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> $past(valid_s2))
		else $error("Hit without a compared entry.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.new_cluster && result.table_full))
		else $error("New cluster and full flags both set.");

endmodule

// File: rtl/threshold_cluster_assign_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_cluster_assign_top: sequential leader clustering of points
// Assigns each point to the first stored mode within the squared threshold,
// or appends it as a new mode while the table has room; else it flags table_full.
//
//   Channel   Signals                          Handshake
//   point     start, busy, point               taken when start && !busy
//   result    done, result                     one cycle, no back pressure
//   config    psel/penable/pwrite/paddr/...    APB, pready tied high
//
// A classify item with N stored modes compares against them in table order until a hit;
// the single read port of the mode table feeds one distance compare per cycle.
// A clear item returns its result in the cycle after it is taken.
// Reset empties the table at once; there is no clearing pass.
// The next item may be offered while a result is on the output.
// ----------------------------------------------------------------------------
module threshold_cluster_assign_top
	import tca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tca_in_t     point,
	output logic        done,
	output tca_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam logic REG_THRESHOLD = 1'b0;

	logic [THR_W-1:0] threshold_q;
	tca_cmd_t         cmd;
	tca_status_t      status;
	logic             reg_sel;

	assign reg_sel = paddr[3];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_W'(65536);
		end else if (psel && penable && pwrite && (reg_sel == REG_THRESHOLD)) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_THRESHOLD) ? 64'(threshold_q) : '0;

	tca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (point.kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.point     (point),
		.threshold (threshold_q),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for threshold_cluster_assign_top
// Drives classify and clear items through the start/busy port and programs the
// squared threshold over APB. It predicts every result with its own mode table
// and compares each done strobe field by field. The run covers directed
// boundary points, a full mode table and randomized phases of clustered points
// under several thresholds.
// ----------------------------------------------------------------------------
module testbench;
	import tca_pkg::*;

	localparam int               CLK_HALF     = 5;
	localparam int               STALL_LIMIT  = 4000;
	localparam int               PHASE_ITEMS  = 150;
	localparam logic [3:0]       ADDR_THRESH  = 4'd0;
	localparam logic [3:0]       ADDR_UNUSED  = 4'd8;
	localparam logic [THR_W-1:0] THRESH_RESET = 34'd65536;
	localparam logic [THR_W-1:0] THRESH_MAX   = {THR_W{1'b1}};

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	tca_in_t     point   = '0;
	logic        done;
	tca_out_t    result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [63:0] pwdata  = '0;
	logic [63:0] prdata;
	logic        pready;

	logic signed [COORD_W-1:0] mode_store [MAX_CLUSTERS][3];
	int unsigned               mode_total  = 0;
	logic [THR_W-1:0]          thresh_sq   = THRESH_RESET;
	tca_out_t                  pending_results[$];
	int                        err_count   = 0;
	int                        gap_pct     = 25;
	int                        stall_count = 0;

	threshold_cluster_assign_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.point   (point),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	function automatic longint unsigned point_dist_sq(tca_in_t p, int unsigned m);
		longint d0, d1, d2;
		d0 = longint'(p.coord_0) - longint'(mode_store[m][0]);
		d1 = longint'(p.coord_1) - longint'(mode_store[m][1]);
		d2 = longint'(p.coord_2) - longint'(mode_store[m][2]);
		return longint'(d0 * d0 + d1 * d1 + d2 * d2);
	endfunction

	function automatic tca_out_t classify_point(tca_in_t p);
		tca_out_t    r;
		int unsigned c;
		int unsigned hit;
		bit          found;
		r     = '0;
		hit   = 0;
		found = 1'b0;
		if (p.kind == KIND_CLEAR) begin
			mode_total = 0;
			return r;
		end
		for (c = 0; c < mode_total; c++) begin
			if (!found && point_dist_sq(p, c) <= longint'(thresh_sq)) begin
				found = 1'b1;
				hit   = c;
			end
		end
		if (found) begin
			r.mode_0        = mode_store[hit][0];
			r.mode_1        = mode_store[hit][1];
			r.mode_2        = mode_store[hit][2];
			r.cluster_index = OUT_IDX_W'(hit);
		end else begin
			r.mode_0 = p.coord_0;
			r.mode_1 = p.coord_1;
			r.mode_2 = p.coord_2;
			if (mode_total < MAX_CLUSTERS) begin
				mode_store[mode_total][0] = p.coord_0;
				mode_store[mode_total][1] = p.coord_1;
				mode_store[mode_total][2] = p.coord_2;
				r.cluster_index           = OUT_IDX_W'(mode_total);
				r.new_cluster             = 1'b1;
				mode_total++;
			end else begin
				r.table_full = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic tca_in_t make_item(logic k, int c0, int c1, int c2);
		tca_in_t it;
		it.kind    = k;
		it.coord_0 = COORD_W'(c0);
		it.coord_1 = COORD_W'(c1);
		it.coord_2 = COORD_W'(c2);
		return it;
	endfunction

	function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] base,
			int spread);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return COORD_W'(v);
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		tca_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no item outstanding");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("mode_0", want.mode_0, result.mode_0);
				check_field("mode_1", want.mode_1, result.mode_1);
				check_field("mode_2", want.mode_2, result.mode_2);
				check_field("cluster_index", want.cluster_index, result.cluster_index);
				check_field("new_cluster", want.new_cluster, result.new_cluster);
				check_field("table_full", want.table_full, result.table_full);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done || (psel && penable))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input tca_in_t it);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		point <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(classify_point(it));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold_reg(input logic [3:0] addr, input logic [63:0] data);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_THRESH)
			thresh_sq = data[THR_W-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_THRESH;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("match_threshold_sq", thresh_sq, prdata[THR_W-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_threshold_register();
		write_threshold_reg(ADDR_UNUSED, {$urandom(), $urandom()});
		write_threshold_reg(ADDR_THRESH, 64'hFFFF_FFFF_0001_0000);
		write_threshold_reg(ADDR_THRESH, 64'd0);
		write_threshold_reg(ADDR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_threshold_reg(ADDR_THRESH, 64'(THRESH_RESET));
	endtask

	task automatic test_directed_points();
		gap_pct = 25;
		send_item(make_item(KIND_CLEAR, -1, -1, -1));
		send_item(make_item(KIND_CLASSIFY, 0, 0, 0));
		send_item(make_item(KIND_CLASSIFY, 256, 0, 0));
		send_item(make_item(KIND_CLASSIFY, 0, 257, 0));
		send_item(make_item(KIND_CLASSIFY, 0, 0, -256));
		send_item(make_item(KIND_CLASSIFY, -32768, -32768, -32768));
		send_item(make_item(KIND_CLASSIFY, 32767, 32767, 32767));
		send_item(make_item(KIND_CLASSIFY, -32768, -32768, -32768));
		send_item(make_item(KIND_CLASSIFY, 'h5555, 'hAAAA, 'h5555));
		send_item(make_item(KIND_CLASSIFY, 'hAAAA, 'h5555, 'hAAAA));
		write_threshold_reg(ADDR_THRESH, 64'(THRESH_MAX));
		send_item(make_item(KIND_CLASSIFY, 32767, 32767, 32767));
		send_item(make_item(KIND_CLASSIFY, -32768, -32768, -32768));
		write_threshold_reg(ADDR_THRESH, 64'd0);
		send_item(make_item(KIND_CLASSIFY, 1, 0, 0));
		send_item(make_item(KIND_CLASSIFY, 1, 0, 0));
		send_item(make_item(KIND_CLASSIFY, 0, 0, 0));
		send_item(make_item(KIND_CLEAR, 'h5555, 'hAAAA, 'h5555));
		send_item(make_item(KIND_CLASSIFY, 32767, -32768, 1));
		send_item(make_item(KIND_CLASSIFY, 32767, -32768, 1));
		write_threshold_reg(ADDR_THRESH, 64'(THRESH_RESET));
	endtask

	task automatic test_full_table();
		int i;
		int k;
		gap_pct = 25;
		write_threshold_reg(ADDR_THRESH, 64'd0);
		send_item(make_item(KIND_CLEAR, 0, 0, 0));
		for (i = 0; i < MAX_CLUSTERS; i++)
			send_item(make_item(KIND_CLASSIFY, i - 128, $urandom(), $urandom()));
		for (i = 0; i < 8; i++)
			send_item(make_item(KIND_CLASSIFY, 1000 + i, $urandom(), $urandom()));
		for (i = 0; i < 8; i++) begin
			k = $urandom_range(0, MAX_CLUSTERS - 1);
			send_item(make_item(KIND_CLASSIFY, mode_store[k][0], mode_store[k][1],
				mode_store[k][2]));
		end
		write_threshold_reg(ADDR_THRESH, 64'(THRESH_MAX));
		send_item(make_item(KIND_CLASSIFY, $urandom(), $urandom(), $urandom()));
		send_item(make_item(KIND_CLEAR, $urandom(), $urandom(), $urandom()));
		send_item(make_item(KIND_CLASSIFY, $urandom(), $urandom(), $urandom()));
		send_item(make_item(KIND_CLASSIFY, $urandom(), $urandom(), $urandom()));
	endtask

	task automatic run_phase(input int items, input int gaps);
		logic signed [COORD_W-1:0] centers [8][3];
		logic [63:0]               thr;
		int                        spread;
		int                        i;
		int                        c;
		int                        pick;
		case ($urandom_range(0, 5))
			0: thr = 64'd0;
			1: thr = 64'(THRESH_RESET);
			2: thr = 64'(THRESH_MAX);
			3: thr = 64'($urandom_range(0, 1 << 18));
			4: thr = 64'($urandom_range(0, 1 << 26));
			default: thr = {$urandom(), $urandom()};
		endcase
		write_threshold_reg(ADDR_THRESH, thr);
		gap_pct = gaps;
		for (c = 0; c < 8; c++) begin
			centers[c][0] = COORD_W'($urandom());
			centers[c][1] = COORD_W'($urandom());
			centers[c][2] = COORD_W'($urandom());
		end
		case ($urandom_range(0, 4))
			0: spread = 0;
			1: spread = 64;
			2: spread = 256;
			3: spread = 1024;
			default: spread = 8192;
		endcase
		for (i = 0; i < items; i++) begin
			pick = $urandom_range(0, 99);
			c    = $urandom_range(0, 7);
			if (pick < 2)
				send_item(make_item(KIND_CLEAR, $urandom(), $urandom(), $urandom()));
			else if (pick < 12)
				send_item(make_item(KIND_CLASSIFY, $urandom(), $urandom(), $urandom()));
			else
				send_item(make_item(KIND_CLASSIFY, near_coord(centers[c][0], spread),
					near_coord(centers[c][1], spread), near_coord(centers[c][2], spread)));
		end
	endtask

	task automatic test_random_clusters();
		int p;
		int gaps;
		for (p = 0; p < 8; p++) begin
			case ($urandom_range(0, 2))
				0: gaps = 0;
				1: gaps = 25;
				default: gaps = 50;
			endcase
			run_phase(PHASE_ITEMS, gaps);
		end
		run_phase(100, 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_threshold_register();
		test_directed_points();
		test_full_table();
		test_random_clusters();
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/tca_pkg.sv
rtl/tca_ctrl.sv
rtl/tca_dp.sv
rtl/threshold_cluster_assign_top.sv
tb/sv/testbench.sv
